>>> rtl/core/btm_pkg.sv
// Shared types, codes and microcode ROM for the bracket tape machine.
`default_nettype none

package btm_pkg;

    localparam int TAPE_DEPTH_DEF    = 4096;
    localparam int PROGRAM_DEPTH_DEF = 4096;
    localparam int CELL_WIDTH_DEF    = 32;

    localparam int KIND_W   = 2;
    localparam int ADDR_W   = 12;
    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 3;
    localparam int PPOS_W   = 13;
    localparam int DPOS_W   = 12;
    localparam int LEN_W    = 13;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    // register index, taken from paddr above the byte offset
    localparam logic REG_PROGRAM_LENGTH = 1'b0;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_END       = 3'd1;
    localparam logic [STATUS_W-1:0] ST_OVER      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_UNDER     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_UNMATCHED = 3'd4;

    localparam logic [BYTE_W-1:0] CH_OPEN  = 8'h5B;
    localparam logic [BYTE_W-1:0] CH_CLOSE = 8'h5D;
    localparam logic [BYTE_W-1:0] CH_RIGHT = 8'h3E;
    localparam logic [BYTE_W-1:0] CH_LEFT  = 8'h3C;
    localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [BYTE_W-1:0] CH_DOT   = 8'h2E;

    localparam logic [8:0] CHAR_MOD = 9'd255;

    typedef enum logic [KIND_W-1:0] {
        K_LOAD  = 2'd0,
        K_STEP  = 2'd1,
        K_CLEAR = 2'd2
    } t_btm_kind;

    typedef enum logic [3:0] {
        CLS_STOPPED,
        CLS_END,
        CLS_RIGHT,
        CLS_LEFT,
        CLS_INC,
        CLS_DEC,
        CLS_EMIT,
        CLS_SKIP,
        CLS_FWD,
        CLS_BACK
    } t_btm_cls;

    typedef enum logic [4:0] {
        U_RST_WIPE,
        U_IDLE,
        U_LOAD,
        U_CLR,
        U_CLR_WIPE,
        U_CLR_DONE,
        U_STEP,
        U_STOPPED,
        U_END,
        U_RIGHT,
        U_LEFT,
        U_INC,
        U_DEC,
        U_EMIT,
        U_SKIP,
        U_FWD,
        U_BACK,
        U_SCAN,
        U_SCAN_FIN
    } t_btm_upc;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_LOAD,
        OP_CLR_INIT,
        OP_WIPE,
        OP_REPORT,
        OP_REPORT_END,
        OP_FETCH,
        OP_RIGHT,
        OP_LEFT,
        OP_INC,
        OP_DEC,
        OP_EMIT,
        OP_SKIP,
        OP_SCAN_INIT_F,
        OP_SCAN_INIT_B,
        OP_SCAN_STEP,
        OP_SCAN_FIN
    } t_btm_op;

    typedef enum logic [2:0] {
        C_NEXT,
        C_KIND,
        C_CLASS,
        C_SCAN,
        C_WIPE
    } t_btm_cond;

    typedef struct packed {
        t_btm_op   op;
        t_btm_cond cond;
        t_btm_upc  target;
        t_btm_upc  next;
    } t_btm_cw;

    typedef struct packed {
        logic      start;
        t_btm_kind kind;
        t_btm_cls  cls;
        logic      scan_stop;
        logic      wipe_last;
    } t_btm_flags;

    function automatic t_btm_cw btm_cw(t_btm_op op, t_btm_cond cond, t_btm_upc target,
                                       t_btm_upc next);
        t_btm_cw cw;
        cw.op     = op;
        cw.cond   = cond;
        cw.target = target;
        cw.next   = next;
        return cw;
    endfunction

    // control store: one word per step
    function automatic t_btm_cw btm_ucode(t_btm_upc a);
        t_btm_cw cw;
        case (a)
            U_RST_WIPE: cw = btm_cw(OP_WIPE,        C_WIPE,  U_IDLE,     U_RST_WIPE);
            U_IDLE:     cw = btm_cw(OP_ACCEPT,      C_KIND,  U_IDLE,     U_IDLE);
            U_LOAD:     cw = btm_cw(OP_LOAD,        C_NEXT,  U_IDLE,     U_IDLE);
            U_CLR:      cw = btm_cw(OP_CLR_INIT,    C_NEXT,  U_IDLE,     U_CLR_WIPE);
            U_CLR_WIPE: cw = btm_cw(OP_WIPE,        C_WIPE,  U_CLR_DONE, U_CLR_WIPE);
            U_CLR_DONE: cw = btm_cw(OP_REPORT,      C_NEXT,  U_IDLE,     U_IDLE);
            U_STEP:     cw = btm_cw(OP_FETCH,       C_CLASS, U_IDLE,     U_IDLE);
            U_STOPPED:  cw = btm_cw(OP_REPORT,      C_NEXT,  U_IDLE,     U_IDLE);
            U_END:      cw = btm_cw(OP_REPORT_END,  C_NEXT,  U_IDLE,     U_IDLE);
            U_RIGHT:    cw = btm_cw(OP_RIGHT,       C_NEXT,  U_IDLE,     U_IDLE);
            U_LEFT:     cw = btm_cw(OP_LEFT,        C_NEXT,  U_IDLE,     U_IDLE);
            U_INC:      cw = btm_cw(OP_INC,         C_NEXT,  U_IDLE,     U_IDLE);
            U_DEC:      cw = btm_cw(OP_DEC,         C_NEXT,  U_IDLE,     U_IDLE);
            U_EMIT:     cw = btm_cw(OP_EMIT,        C_NEXT,  U_IDLE,     U_IDLE);
            U_SKIP:     cw = btm_cw(OP_SKIP,        C_NEXT,  U_IDLE,     U_IDLE);
            U_FWD:      cw = btm_cw(OP_SCAN_INIT_F, C_NEXT,  U_IDLE,     U_SCAN);
            U_BACK:     cw = btm_cw(OP_SCAN_INIT_B, C_NEXT,  U_IDLE,     U_SCAN);
            U_SCAN:     cw = btm_cw(OP_SCAN_STEP,   C_SCAN,  U_SCAN_FIN, U_SCAN);
            U_SCAN_FIN: cw = btm_cw(OP_SCAN_FIN,    C_NEXT,  U_IDLE,     U_IDLE);
            default:    cw = btm_cw(OP_NONE,        C_NEXT,  U_IDLE,     U_IDLE);
        endcase
        return cw;
    endfunction

    function automatic t_btm_upc btm_dispatch(t_btm_cls c);
        t_btm_upc u;
        case (c)
            CLS_STOPPED: u = U_STOPPED;
            CLS_END:     u = U_END;
            CLS_RIGHT:   u = U_RIGHT;
            CLS_LEFT:    u = U_LEFT;
            CLS_INC:     u = U_INC;
            CLS_DEC:     u = U_DEC;
            CLS_EMIT:    u = U_EMIT;
            CLS_FWD:     u = U_FWD;
            CLS_BACK:    u = U_BACK;
            default:     u = U_SKIP;
        endcase
        return u;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/bracket_tape_machine_step.sv
// Top level of the bracket tape machine: datapath, memories and config port.
//
// Usage: an item is taken when start is high and busy is low. kind selects a
// program byte load (load_address, load_byte), one interpreter step, or a
// clear of the tape and both pointers. Every item gives exactly one result,
// shown for one cycle with o_strobe; the receiver cannot hold it off.
// program_length is written through the APB port at byte address 0. It is
// to be changed only while the block is idle; the block does not enforce it.
// Each item runs through the microcode sequencer and the registered read
// ports of the two memories: a load through U_LOAD; a plain step (pointer,
// cell, output, no jump) through U_STEP and its operation word; a bracket
// jump through U_STEP, U_FWD or U_BACK, U_SCAN (one program byte per cycle)
// and U_SCAN_FIN; a clear through U_CLR, U_CLR_WIPE (tape wiped one cell
// per cycle) and U_CLR_DONE. The strobe is registered from the last of these.
// busy drops in the strobe cycle, so the next item may be taken there.
// After reset the tape is wiped with busy high; configuration writes are
// taken during that pass.
`default_nettype none

module bracket_tape_machine_step #(
    parameter int TAPE_DEPTH    = btm_pkg::TAPE_DEPTH_DEF,
    parameter int PROGRAM_DEPTH = btm_pkg::PROGRAM_DEPTH_DEF,
    parameter int CELL_WIDTH    = btm_pkg::CELL_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [btm_pkg::KIND_W-1:0]  i_kind,
    input  logic [btm_pkg::ADDR_W-1:0]  i_load_address,
    input  logic [btm_pkg::BYTE_W-1:0]  i_load_byte,
    output logic                        o_strobe,
    output logic                        o_char_valid,
    output logic [btm_pkg::BYTE_W-1:0]  o_out_char,
    output logic [btm_pkg::STATUS_W-1:0] o_status,
    output logic [btm_pkg::PPOS_W-1:0]  o_program_position,
    output logic [btm_pkg::DPOS_W-1:0]  o_data_position,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [btm_pkg::APB_AW-1:0]  paddr,
    input  logic [btm_pkg::APB_DW-1:0]  pwdata,
    output logic [btm_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);
    import btm_pkg::*;

    localparam int PA  = $clog2(PROGRAM_DEPTH);
    localparam int PCW = $clog2(PROGRAM_DEPTH + 1);
    localparam int DW  = $clog2(TAPE_DEPTH);
    localparam int LW  = (PCW > LEN_W) ? PCW : LEN_W;

    // configuration
    logic [LEN_W-1:0]  r_prog_len;
    logic [PCW-1:0]    len_eff;

    // machine state
    logic [PCW-1:0]    r_pc, n_pc;
    logic [DW-1:0]     r_dp, n_dp;
    logic [PCW-1:0]    r_depth, n_depth;
    logic [STATUS_W-1:0] r_stop, n_stop;
    logic [DW-1:0]     r_wipe, n_wipe;

    // work registers
    logic [PCW-1:0]    r_scan, n_scan;
    logic              r_found, n_found;
    logic              r_back, n_back;
    t_btm_kind         r_kind, n_kind;
    logic [ADDR_W-1:0] r_addr, n_addr;
    logic [BYTE_W-1:0] r_byte, n_byte;
    logic [CELL_WIDTH-1:0] r_cell, n_cell;

    // result registers
    logic              r_strobe, n_strobe;
    logic              r_char_valid, n_char_valid;
    logic [BYTE_W-1:0] r_out_char, n_out_char;
    logic [STATUS_W-1:0] r_status, n_status;

    // memories
    logic [CELL_WIDTH-1:0] r_tape [TAPE_DEPTH];
    logic [CELL_WIDTH-1:0] r_tape_rd;
    logic                  tape_we;
    logic [DW-1:0]         tape_wa;
    logic [CELL_WIDTH-1:0] tape_wd;
    logic [BYTE_W-1:0]     r_prog_mem [PROGRAM_DEPTH];
    logic [BYTE_W-1:0]     r_prog_rd;
    logic                  prog_we;
    logic [PA-1:0]         prog_wa;
    logic [PCW-1:0]        prog_raddr;
    logic                  prog_re;

    // control
    t_btm_op           op;
    t_btm_flags        flags;
    t_btm_cls          cls;
    logic              accept;
    logic              cfg_wr;
    logic              tape_zero;
    logic              wipe_last;
    logic              scan_miss;
    logic              scan_hit;
    logic [BYTE_W-1:0] open_b;
    logic [BYTE_W-1:0] close_b;

    function automatic logic [BYTE_W-1:0] mod255(input logic [31:0] x);
        logic [9:0] s;
        logic [8:0] t;
        // 2^8 == 1 (mod 255): fold the bytes, then one correction
        s = 10'(x[7:0]) + 10'(x[15:8]) + 10'(x[23:16]) + 10'(x[31:24]);
        t = 9'(s[7:0]) + 9'(s[9:8]);
        if (t >= CHAR_MOD) begin
            t = t - CHAR_MOD;
        end
        return t[BYTE_W-1:0];
    endfunction

    btm_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (flags),
        .o_op    (op),
        .o_busy  (busy)
    );

    // APB register
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = (paddr[APB_AW-1] == REG_PROGRAM_LENGTH) ? APB_DW'(r_prog_len) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prog_len <= '0;
        end else if (cfg_wr && (paddr[APB_AW-1] == REG_PROGRAM_LENGTH)) begin
            r_prog_len <= pwdata[LEN_W-1:0];
        end
    end

    assign len_eff = (LW'(r_prog_len) > LW'(PROGRAM_DEPTH)) ? PCW'(PROGRAM_DEPTH)
                                                            : PCW'(r_prog_len);

    assign accept    = start && !busy;
    assign tape_zero = (r_tape_rd == '0);
    assign wipe_last = (r_wipe == DW'(TAPE_DEPTH - 1));

    // bracket scan: open_b deepens, close_b unwinds, direction from r_back
    assign open_b    = r_back ? CH_CLOSE : CH_OPEN;
    assign close_b   = r_back ? CH_OPEN : CH_CLOSE;
    assign scan_miss = r_back ? (r_scan >= PCW'(PROGRAM_DEPTH)) : (r_scan >= len_eff);
    assign scan_hit  = !scan_miss && (r_prog_rd == close_b) && (r_depth == PCW'(1));

    always_comb begin
        if (r_stop != ST_OK) begin
            cls = CLS_STOPPED;
        end else if (r_pc >= len_eff) begin
            cls = CLS_END;
        end else begin
            case (r_prog_rd)
                CH_RIGHT: cls = CLS_RIGHT;
                CH_LEFT:  cls = CLS_LEFT;
                CH_PLUS:  cls = CLS_INC;
                CH_MINUS: cls = CLS_DEC;
                CH_DOT:   cls = CLS_EMIT;
                CH_OPEN:  cls = tape_zero ? CLS_FWD : CLS_SKIP;
                CH_CLOSE: cls = tape_zero ? CLS_SKIP : CLS_BACK;
                default:  cls = CLS_SKIP;
            endcase
        end
    end

    always_comb begin
        flags.start     = start;
        flags.kind      = t_btm_kind'(i_kind);
        flags.cls       = cls;
        flags.scan_stop = scan_miss || scan_hit;
        flags.wipe_last = wipe_last;
    end

    // datapath micro-operations
    always_comb begin
        n_pc         = r_pc;
        n_dp         = r_dp;
        n_depth      = r_depth;
        n_stop       = r_stop;
        n_wipe       = r_wipe;
        n_scan       = r_scan;
        n_found      = r_found;
        n_back       = r_back;
        n_kind       = r_kind;
        n_addr       = r_addr;
        n_byte       = r_byte;
        n_cell       = r_cell;
        n_strobe     = 1'b0;
        n_char_valid = 1'b0;
        n_out_char   = '0;
        n_status     = r_status;
        tape_we      = 1'b0;
        tape_wa      = r_dp;
        tape_wd      = r_cell;
        prog_we      = 1'b0;
        prog_raddr   = r_pc;
        case (op)
            OP_ACCEPT: begin
                if (accept) begin
                    n_kind = t_btm_kind'(i_kind);
                    n_addr = i_load_address;
                    n_byte = i_load_byte;
                end
            end
            OP_LOAD: begin
                prog_we  = (r_kind == K_LOAD) && (32'(r_addr) < PROGRAM_DEPTH);
                n_strobe = 1'b1;
                n_status = r_stop;
            end
            OP_CLR_INIT: begin
                n_pc    = '0;
                n_dp    = '0;
                n_depth = '0;
                n_stop  = ST_OK;
                n_wipe  = '0;
            end
            OP_WIPE: begin
                tape_we = 1'b1;
                tape_wa = r_wipe;
                tape_wd = '0;
                n_wipe  = wipe_last ? '0 : r_wipe + DW'(1);
            end
            OP_REPORT: begin
                n_strobe = 1'b1;
                n_status = r_stop;
            end
            OP_REPORT_END: begin
                n_strobe = 1'b1;
                n_status = ST_END;
            end
            OP_FETCH: begin
                n_cell = r_tape_rd;
            end
            OP_RIGHT: begin
                n_strobe = 1'b1;
                if (r_dp != DW'(TAPE_DEPTH - 1)) begin
                    n_dp     = r_dp + DW'(1);
                    n_pc     = r_pc + PCW'(1);
                    n_status = ST_OK;
                end else begin
                    n_stop   = ST_OVER;
                    n_status = ST_OVER;
                end
            end
            OP_LEFT: begin
                n_strobe = 1'b1;
                if (r_dp != '0) begin
                    n_dp     = r_dp - DW'(1);
                    n_pc     = r_pc + PCW'(1);
                    n_status = ST_OK;
                end else begin
                    n_stop   = ST_UNDER;
                    n_status = ST_UNDER;
                end
            end
            OP_INC: begin
                tape_we  = 1'b1;
                tape_wd  = r_cell + CELL_WIDTH'(1);
                n_pc     = r_pc + PCW'(1);
                n_strobe = 1'b1;
                n_status = ST_OK;
            end
            OP_DEC: begin
                tape_we  = 1'b1;
                tape_wd  = r_cell - CELL_WIDTH'(1);
                n_pc     = r_pc + PCW'(1);
                n_strobe = 1'b1;
                n_status = ST_OK;
            end
            OP_EMIT: begin
                n_char_valid = 1'b1;
                n_out_char   = mod255(32'(r_cell));
                n_pc         = r_pc + PCW'(1);
                n_strobe     = 1'b1;
                n_status     = ST_OK;
            end
            OP_SKIP: begin
                n_pc     = r_pc + PCW'(1);
                n_strobe = 1'b1;
                n_status = ST_OK;
            end
            OP_SCAN_INIT_F: begin
                n_back     = 1'b0;
                n_found    = 1'b0;
                n_depth    = PCW'(1);
                n_scan     = r_pc + PCW'(1);
                prog_raddr = r_pc + PCW'(1);
            end
            OP_SCAN_INIT_B: begin
                // from pc 0 this wraps to all ones, which reads as a miss
                n_back     = 1'b1;
                n_found    = 1'b0;
                n_depth    = PCW'(1);
                n_scan     = r_pc - PCW'(1);
                prog_raddr = r_pc - PCW'(1);
            end
            OP_SCAN_STEP: begin
                // read data belongs to r_scan; the address runs one ahead
                if (!scan_miss) begin
                    if (r_prog_rd == open_b) begin
                        n_depth = r_depth + PCW'(1);
                    end else if (r_prog_rd == close_b) begin
                        n_depth = r_depth - PCW'(1);
                    end
                    // on a hit r_scan ends one past the partner: the new pc
                    n_scan = (scan_hit || !r_back) ? r_scan + PCW'(1) : r_scan - PCW'(1);
                end
                n_found    = scan_hit;
                prog_raddr = n_scan;
            end
            OP_SCAN_FIN: begin
                n_strobe = 1'b1;
                if (r_found) begin
                    n_pc     = r_scan;
                    n_status = ST_OK;
                end else begin
                    n_stop   = ST_UNMATCHED;
                    n_status = ST_UNMATCHED;
                end
            end
            default: begin
            end
        endcase
    end

    assign prog_re = (prog_raddr < PCW'(PROGRAM_DEPTH));
    assign prog_wa = PA'(r_addr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc     <= '0;
            r_dp     <= '0;
            r_depth  <= '0;
            r_stop   <= ST_OK;
            r_wipe   <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_pc     <= n_pc;
            r_dp     <= n_dp;
            r_depth  <= n_depth;
            r_stop   <= n_stop;
            r_wipe   <= n_wipe;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_scan       <= n_scan;
        r_found      <= n_found;
        r_back       <= n_back;
        r_kind       <= n_kind;
        r_addr       <= n_addr;
        r_byte       <= n_byte;
        r_cell       <= n_cell;
        r_char_valid <= n_char_valid;
        r_out_char   <= n_out_char;
        r_status     <= n_status;
    end

    // tape: one write port, one registered read port at the data pointer
    always_ff @(posedge i_clk) begin
        if (tape_we) begin
            r_tape[tape_wa] <= tape_wd;
        end
        r_tape_rd <= r_tape[r_dp];
    end

    // program store
    always_ff @(posedge i_clk) begin
        if (prog_we) begin
            r_prog_mem[prog_wa] <= r_byte;
        end
        if (prog_re) begin
            r_prog_rd <= r_prog_mem[prog_raddr[PA-1:0]];
        end
    end

    assign o_strobe           = r_strobe;
    assign o_char_valid       = r_char_valid;
    assign o_out_char         = r_out_char;
    assign o_status           = r_status;
    assign o_program_position = PPOS_W'(r_pc);
    assign o_data_position    = DPOS_W'(r_dp);

`ifndef SYNTHESIS
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |-> !busy)
        else $error("result transfer while sequencer busy");

    a_accept_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !r_strobe)
        else $error("result transfer right after accept");

    a_emit_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && r_char_valid) |-> (r_status == ST_OK))
        else $error("character emitted with error status");

    a_over_dp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && (r_status == ST_OVER)) |-> (r_dp == DW'(TAPE_DEPTH - 1)))
        else $error("overflow reported off the last cell");

    a_under_dp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && (r_status == ST_UNDER)) |-> (r_dp == '0))
        else $error("underflow reported off cell zero");
`endif

endmodule

`default_nettype wire

>>> rtl/core/btm_seq.sv
// Microcode sequencer: step counter, control store lookup and jump logic.
`default_nettype none

module btm_seq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  btm_pkg::t_btm_flags i_flags,
    output btm_pkg::t_btm_op    o_op,
    output logic                o_busy
);
    import btm_pkg::*;

    t_btm_upc r_upc;
    t_btm_upc n_upc;
    t_btm_cw  cw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= U_RST_WIPE;
        end else begin
            r_upc <= n_upc;
        end
    end

    always_comb begin
        cw    = btm_ucode(r_upc);
        n_upc = cw.next;
        case (cw.cond)
            C_NEXT: begin
                n_upc = cw.next;
            end
            C_KIND: begin
                if (i_flags.start) begin
                    case (i_flags.kind)
                        K_STEP:  n_upc = U_STEP;
                        K_CLEAR: n_upc = U_CLR;
                        default: n_upc = U_LOAD;
                    endcase
                end
            end
            C_CLASS: begin
                n_upc = btm_dispatch(i_flags.cls);
            end
            C_SCAN: begin
                if (i_flags.scan_stop) begin
                    n_upc = cw.target;
                end
            end
            C_WIPE: begin
                if (i_flags.wipe_last) begin
                    n_upc = cw.target;
                end
            end
            default: begin
                n_upc = U_IDLE;
            end
        endcase
        o_op   = cw.op;
        o_busy = (r_upc != U_IDLE);
    end

endmodule

`default_nettype wire
